// File: rtl/lbsc_pkg.sv
// ----------------------------------------------------------------------------
// lbsc_pkg
// Types, codes and the control-store contents for the balance and steering
// controller.
// ----------------------------------------------------------------------------
package lbsc_pkg;

  localparam int STEP_W     = 4;
  localparam int CFG_ADDR_W = 4;

  typedef struct packed {
    logic               operation;
    logic               enable_value;
    logic signed [31:0] pitch_angle;
    logic signed [31:0] pitch_rate;
    logic signed [31:0] yaw_rate;
    logic signed [31:0] wheel_speed;
    logic signed [31:0] speed_target;
    logic signed [31:0] yaw_rate_target;
  } in_item_t;

  typedef enum logic [1:0] {
    ACT_STOP  = 2'd0,
    ACT_APPLY = 2'd1,
    ACT_NONE  = 2'd2
  } drive_action_t;

  typedef struct packed {
    logic signed [15:0] pwm_left_out;
    logic signed [15:0] pwm_right_out;
    drive_action_t      drive_action;
    logic               tilt_trip;
    logic               distance_reset;
    logic               enabled_now;
  } out_item_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_GAIN_ANGLE      = 4'd0,
    CFG_GAIN_ANGLE_RATE = 4'd1,
    CFG_GAIN_POSITION   = 4'd2,
    CFG_GAIN_SPEED      = 4'd3,
    CFG_STEER_GAIN      = 4'd4,
    CFG_PITCH_OFFSET    = 4'd5,
    CFG_OUTPUT_SCALE    = 4'd6,
    CFG_TICK_PERIOD     = 4'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] gain_angle;
    logic signed [31:0] gain_angle_rate;
    logic signed [31:0] gain_position;
    logic signed [31:0] gain_speed;
    logic signed [31:0] steer_gain;
    logic signed [31:0] pitch_offset;
    logic signed [31:0] output_scale;
    logic        [16:0] tick_period;
  } cfg_regs_t;

  // Operand pair fed to the shared multiplier
  typedef enum logic [2:0] {
    MS_NONE        = 3'd0,
    MS_SERR_PERIOD = 3'd1,
    MS_ANGLE       = 3'd2,
    MS_RATE        = 3'd3,
    MS_POSITION    = 3'd4,
    MS_SPEED       = 3'd5,
    MS_STEER       = 3'd6,
    MS_SCALE       = 3'd7
  } mul_sel_t;

  typedef enum logic [3:0] {
    OP_NOP      = 4'd0,
    OP_LOAD_IN  = 4'd1,
    OP_DISP     = 4'd2,
    OP_ACC_LOAD = 4'd3,
    OP_ACC_ADD  = 4'd4,
    OP_TURN     = 4'd5,
    OP_EFF_SUM  = 4'd6,
    OP_EFF_DIFF = 4'd7,
    OP_PWM_L    = 4'd8,
    OP_PWM_R    = 4'd9
  } alu_op_t;

  typedef enum logic [1:0] {
    JC_NONE     = 2'd0,
    JC_SET_EN   = 2'd1,
    JC_DISABLED = 2'd2,
    JC_TILT     = 2'd3
  } jump_cond_t;

  typedef enum logic [2:0] {
    FIN_NONE   = 3'd0,
    FIN_ENABLE = 3'd1,
    FIN_STOP   = 3'd2,
    FIN_TRIP   = 3'd3,
    FIN_RUN    = 3'd4
  } fin_t;

  typedef struct packed {
    jump_cond_t        jc;
    logic [STEP_W-1:0] target;
    fin_t              fin;
    mul_sel_t          mul;
    alu_op_t           alu;
  } ucode_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    alu_op_t  alu_op;
    logic     disp_clr;
  } dp_ctrl_t;

  typedef struct packed {
    logic               tilt_over;
    logic signed [15:0] left_cmd;
    logic signed [15:0] right_cmd;
  } dp_stat_t;

  localparam logic [STEP_W-1:0] S_FIN_ENABLE = 4'd13;
  localparam logic [STEP_W-1:0] S_FIN_STOP   = 4'd14;
  localparam logic [STEP_W-1:0] S_FIN_TRIP   = 4'd15;

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Control store: multiplier issue in step k, its product used in step k+1
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w.jc     = JC_NONE;
    w.target = '0;
    w.fin    = FIN_NONE;
    w.mul    = MS_NONE;
    w.alu    = OP_NOP;
    unique case (step)
      4'd0: begin
        w.jc     = JC_SET_EN;
        w.target = S_FIN_ENABLE;
      end
      4'd1: begin
        w.jc     = JC_DISABLED;
        w.target = S_FIN_STOP;
        w.alu    = OP_LOAD_IN;
      end
      4'd2: begin
        w.jc     = JC_TILT;
        w.target = S_FIN_TRIP;
        w.mul    = MS_SERR_PERIOD;
      end
      4'd3: begin
        w.alu = OP_DISP;
        w.mul = MS_ANGLE;
      end
      4'd4: begin
        w.alu = OP_ACC_LOAD;
        w.mul = MS_RATE;
      end
      4'd5: begin
        w.alu = OP_ACC_ADD;
        w.mul = MS_POSITION;
      end
      4'd6: begin
        w.alu = OP_ACC_ADD;
        w.mul = MS_SPEED;
      end
      4'd7: begin
        w.alu = OP_ACC_ADD;
        w.mul = MS_STEER;
      end
      4'd8:  w.alu = OP_TURN;
      4'd9:  w.alu = OP_EFF_SUM;
      4'd10: begin
        w.alu = OP_EFF_DIFF;
        w.mul = MS_SCALE;
      end
      4'd11: begin
        w.alu = OP_PWM_L;
        w.mul = MS_SCALE;
      end
      4'd12: begin
        w.alu = OP_PWM_R;
        w.fin = FIN_RUN;
      end
      4'd13: w.fin = FIN_ENABLE;
      4'd14: w.fin = FIN_STOP;
      4'd15: w.fin = FIN_TRIP;
    endcase
    return w;
  endfunction

endpackage

// File: rtl/lbsc_in_if.sv
// ----------------------------------------------------------------------------
// lbsc_in_if
// Request channel into the controller: valid, ready and one input item.
// ----------------------------------------------------------------------------
interface lbsc_in_if;
  logic               valid;
  logic               ready;
  lbsc_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/lbsc_out_if.sv
// ----------------------------------------------------------------------------
// lbsc_out_if
// Result channel out of the controller: valid, ready and one result item.
// ----------------------------------------------------------------------------
interface lbsc_out_if;
  logic                valid;
  logic                ready;
  lbsc_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/lbsc_datapath.sv
// ----------------------------------------------------------------------------
// lbsc_datapath
// Shared 32x32 multiplier, accumulator and saturation logic driven one
// control word per cycle.
// ----------------------------------------------------------------------------
module lbsc_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lbsc_pkg::dp_ctrl_t  ctrl,
  input  lbsc_pkg::in_item_t  item,
  input  lbsc_pkg::cfg_regs_t cfg,
  output lbsc_pkg::dp_stat_t  stat
);
  import lbsc_pkg::*;

  localparam int TERM_W = 64 - FRAC_BITS;
  localparam int DS_W   = TERM_W + 1;
  localparam int ACC_W  = TERM_W + 3;
  localparam int EFF_W  = ACC_W + 1;
  localparam int NW     = 64 - 2 * FRAC_BITS;

  localparam longint TILT_I = ((longint'(61) << FRAC_BITS) + 50) / 100;
  localparam logic signed [32:0] TILT_HI = 33'(TILT_I);
  localparam logic signed [32:0] TILT_LO = -TILT_HI;

  localparam logic signed [DS_W-1:0] DISP_HI = DS_W'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [DS_W-1:0] DISP_LO = -DISP_HI;

  localparam logic signed [EFF_W-1:0] EFF_HI = EFF_W'(64'sd2147483647);
  localparam logic signed [EFF_W-1:0] EFF_LO = -EFF_HI - EFF_W'(64'sd1);

  localparam logic signed [63:0] TRUNC_BIAS = (64'sd1 <<< (2 * FRAC_BITS)) - 64'sd1;

  localparam logic signed [NW:0] PWM_HI  = (NW + 1)'(64'sd32767);
  localparam logic signed [NW:0] PWM_HI1 = (NW + 1)'(64'sd32768);
  localparam logic signed [NW:0] PWM_LO  = (NW + 1)'(-64'sd32768);
  localparam logic signed [NW:0] PWM_LO1 = (NW + 1)'(-64'sd32767);

  logic signed [32:0]       pitch_r;
  logic signed [31:0]       serr_r;
  logic signed [31:0]       yerr_r;
  logic signed [31:0]       disp_r;
  logic signed [63:0]       prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [TERM_W-1:0] turn_r;
  logic signed [31:0]       eff_r;
  logic signed [15:0]       pwm_l_r;

  logic signed [31:0]       mul_a;
  logic signed [31:0]       mul_b;
  logic signed [TERM_W-1:0] term;
  logic signed [DS_W-1:0]   dsum;
  logic signed [31:0]       disp_nxt;
  logic signed [EFF_W-1:0]  eff_sum;
  logic signed [EFF_W-1:0]  eff_diff;
  logic signed [63:0]       biased;
  logic signed [NW-1:0]     quot;
  logic signed [NW:0]       quot_x;
  logic signed [15:0]       pwm_l_nxt;
  logic signed [15:0]       pwm_r_nxt;

  function automatic logic signed [31:0] sat_eff(input logic signed [EFF_W-1:0] v);
    logic signed [31:0] r;
    if (v > EFF_HI) begin
      r = 32'sh7fff_ffff;
    end else if (v < EFF_LO) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctrl.mul_sel)
      MS_NONE: begin
      end
      MS_SERR_PERIOD: begin
        mul_a = serr_r;
        mul_b = $signed(32'(cfg.tick_period));
      end
      MS_ANGLE: begin
        mul_a = cfg.gain_angle;
        mul_b = pitch_r[31:0];
      end
      MS_RATE: begin
        mul_a = cfg.gain_angle_rate;
        mul_b = item.pitch_rate;
      end
      MS_POSITION: begin
        mul_a = cfg.gain_position;
        mul_b = disp_r;
      end
      MS_SPEED: begin
        mul_a = cfg.gain_speed;
        mul_b = serr_r;
      end
      MS_STEER: begin
        mul_a = cfg.steer_gain;
        mul_b = yerr_r;
      end
      MS_SCALE: begin
        mul_a = cfg.output_scale;
        mul_b = eff_r;
      end
    endcase
  end

  // floor shift of the product is its upper bits
  assign term = $signed(prod_r[63:FRAC_BITS]);

  always_comb begin
    dsum = DS_W'(disp_r) + DS_W'(term);
    if (dsum > DISP_HI) begin
      disp_nxt = 32'(DISP_HI);
    end else if (dsum < DISP_LO) begin
      disp_nxt = 32'(DISP_LO);
    end else begin
      disp_nxt = dsum[31:0];
    end
  end

  assign eff_sum  = EFF_W'(turn_r) - EFF_W'(acc_r);
  assign eff_diff = -EFF_W'(acc_r) - EFF_W'(turn_r);

  // truncation toward zero
  assign biased = prod_r[63] ? prod_r + TRUNC_BIAS : prod_r;
  assign quot   = $signed(biased[63:2*FRAC_BITS]);
  assign quot_x = (NW + 1)'(quot);

  always_comb begin
    if (quot_x > PWM_HI) begin
      pwm_l_nxt = 16'sh7fff;
    end else if (quot_x < PWM_LO) begin
      pwm_l_nxt = 16'sh8000;
    end else begin
      pwm_l_nxt = quot[15:0];
    end
    if (quot_x >= PWM_HI1) begin
      pwm_r_nxt = 16'sh8000;
    end else if (quot_x <= PWM_LO1) begin
      pwm_r_nxt = 16'sh7fff;
    end else begin
      pwm_r_nxt = -$signed(quot[15:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_sel != MS_NONE) begin
      prod_r <= mul_a * mul_b;
    end
    unique case (ctrl.alu_op)
      OP_NOP: begin
      end
      OP_LOAD_IN: begin
        pitch_r <= 33'(item.pitch_angle) - 33'(cfg.pitch_offset);
        serr_r  <= sat32(33'(item.wheel_speed) - 33'(item.speed_target));
        yerr_r  <= sat32(33'(item.yaw_rate_target) - 33'(item.yaw_rate));
      end
      OP_DISP: begin
      end
      OP_ACC_LOAD: acc_r   <= ACC_W'(term);
      OP_ACC_ADD:  acc_r   <= acc_r + ACC_W'(term);
      OP_TURN:     turn_r  <= term;
      OP_EFF_SUM:  eff_r   <= sat_eff(eff_sum);
      OP_EFF_DIFF: eff_r   <= sat_eff(eff_diff);
      OP_PWM_L:    pwm_l_r <= pwm_l_nxt;
      // right value goes straight from the held product into the result
      OP_PWM_R: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disp_r <= '0;
    end else if (ctrl.disp_clr) begin
      disp_r <= '0;
    end else if (ctrl.alu_op == OP_DISP) begin
      disp_r <= disp_nxt;
    end
  end

  assign stat.tilt_over = (pitch_r > TILT_HI) || (pitch_r < TILT_LO);
  assign stat.left_cmd  = pwm_l_r;
  assign stat.right_cmd = pwm_r_nxt;

endmodule

// File: rtl/lqr_balance_steer_controller.sv
// ----------------------------------------------------------------------------
// lqr_balance_steer_controller
// LQR balance and proportional steering controller for a two-wheeled robot,
// sequenced from a 16-step control store over one shared multiplier.
// ----------------------------------------------------------------------------
// One request is handled at a time, stepped through a small control store
// that drives a single 32x32 multiplier: an enabled control tick runs through
// to the PWM steps, a set-enable request jumps to its final step, and a tick
// while disabled or tripping on tilt leaves early. A new request is taken
// in the cycle after a result commits; the result waits in the output
// register meanwhile, and the sequencer only stalls at its final step if
// that register is still full. The user must write gains and limits through
// the cfg port while the block is idle; the block itself does not enforce it.
module lqr_balance_steer_controller #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  lbsc_in_if.sink                             in_ch,
  lbsc_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [lbsc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [31:0]                         cfg_wdata
);
  import lbsc_pkg::*;

  localparam int PERIOD_RST = ((1 << FRAC_BITS) + 100) / 200;

  cfg_regs_t         cfg_r;
  in_item_t          item_r;
  logic              busy_r;
  logic [STEP_W-1:0] step_r;
  logic              run_en_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  ucode_t            cw;
  logic              out_free;
  logic              commit;
  logic              jump_take;
  logic              rising;
  logic              run_en_nxt;
  out_item_t         res;
  dp_ctrl_t          dp_ctrl;
  dp_stat_t          dp_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_angle      <= '0;
      cfg_r.gain_angle_rate <= '0;
      cfg_r.gain_position   <= '0;
      cfg_r.gain_speed      <= '0;
      cfg_r.steer_gain      <= '0;
      cfg_r.pitch_offset    <= '0;
      cfg_r.output_scale    <= 32'(64'sd1 <<< FRAC_BITS);
      cfg_r.tick_period     <= 17'(PERIOD_RST);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_GAIN_ANGLE:      cfg_r.gain_angle      <= cfg_wdata;
        CFG_GAIN_ANGLE_RATE: cfg_r.gain_angle_rate <= cfg_wdata;
        CFG_GAIN_POSITION:   cfg_r.gain_position   <= cfg_wdata;
        CFG_GAIN_SPEED:      cfg_r.gain_speed      <= cfg_wdata;
        CFG_STEER_GAIN:      cfg_r.steer_gain      <= cfg_wdata;
        CFG_PITCH_OFFSET:    cfg_r.pitch_offset    <= cfg_wdata;
        CFG_OUTPUT_SCALE:    cfg_r.output_scale    <= cfg_wdata;
        CFG_TICK_PERIOD:     cfg_r.tick_period     <= cfg_wdata[16:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ch.ready = rst_n && !busy_r;
  assign cw          = ucode_rom(step_r);
  assign out_free    = !out_valid_r || out_ch.ready;
  assign commit      = busy_r && (cw.fin != FIN_NONE) && out_free;
  assign rising      = item_r.enable_value && !run_en_r;

  always_comb begin
    unique case (cw.jc)
      JC_NONE:     jump_take = 1'b0;
      JC_SET_EN:   jump_take = item_r.operation;
      JC_DISABLED: jump_take = !run_en_r;
      JC_TILT:     jump_take = dp_stat.tilt_over;
    endcase
  end

  always_comb begin
    dp_ctrl.mul_sel  = busy_r ? cw.mul : MS_NONE;
    dp_ctrl.alu_op   = busy_r ? cw.alu : OP_NOP;
    dp_ctrl.disp_clr = commit && (cw.fin == FIN_ENABLE) && rising;
  end

  always_comb begin
    run_en_nxt         = run_en_r;
    res.pwm_left_out   = '0;
    res.pwm_right_out  = '0;
    res.drive_action   = ACT_STOP;
    res.tilt_trip      = 1'b0;
    res.distance_reset = 1'b0;
    unique case (cw.fin)
      FIN_NONE, FIN_STOP: begin
      end
      FIN_ENABLE: begin
        run_en_nxt         = item_r.enable_value;
        res.drive_action   = ACT_NONE;
        res.distance_reset = rising;
      end
      FIN_TRIP: begin
        run_en_nxt    = 1'b0;
        res.tilt_trip = 1'b1;
      end
      FIN_RUN: begin
        res.drive_action  = ACT_APPLY;
        res.pwm_left_out  = dp_stat.left_cmd;
        res.pwm_right_out = dp_stat.right_cmd;
      end
      default: begin
      end
    endcase
    res.enabled_now = run_en_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r <= in_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      step_r   <= '0;
      run_en_r <= 1'b0;
    end else if (!busy_r) begin
      if (in_ch.valid) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end
    end else if (cw.fin != FIN_NONE) begin
      if (out_free) begin
        busy_r   <= 1'b0;
        step_r   <= '0;
        run_en_r <= run_en_nxt;
      end
    end else if (jump_take) begin
      step_r <= cw.target;
    end else begin
      step_r <= step_r + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data_r <= res;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  lbsc_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (dp_ctrl),
    .item  (item_r),
    .cfg   (cfg_r),
    .stat  (dp_stat)
  );

  // idle sequencer sits at the program start
  a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (step_r == '0))
    else $error("step counter moved while idle");

  // applied PWM only with the block enabled
  a_apply_en: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.drive_action == ACT_APPLY) |-> out_data_r.enabled_now)
    else $error("PWM applied while disabled");

  // a tilt trip stops the motors and leaves the block disabled
  a_trip_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.tilt_trip |->
      (out_data_r.drive_action == ACT_STOP) && !out_data_r.enabled_now && !run_en_r)
    else $error("tilt trip without stop and disable");

  // a distance reset only on an enabling set-enable request
  a_dreset: assert property (@(posedge clk) disable iff (!rst_n)
    commit && res.distance_reset |=> run_en_r && out_data_r.enabled_now &&
      (out_data_r.drive_action == ACT_NONE))
    else $error("distance reset outside a rising enable");

endmodule
